### rtl/sts_pkg.sv
// Shared types, token codes, scanner modes and keyword tables of the source token scanner.
package sts_pkg;

  localparam int unsigned FieldW   = 24;
  localparam int unsigned KindW    = 6;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned KwCount  = 16;

  localparam int unsigned OffsetWidthDef  = 24;
  localparam int unsigned DepthWidthDef   = 8;
  localparam int unsigned HexMaxDigitsDef = 8;
  localparam int unsigned BinMaxDigitsDef = 32;

  localparam logic [KindW-1:0] K_LPAREN    = 6'd0;
  localparam logic [KindW-1:0] K_RPAREN    = 6'd1;
  localparam logic [KindW-1:0] K_LBRACE    = 6'd2;
  localparam logic [KindW-1:0] K_RBRACE    = 6'd3;
  localparam logic [KindW-1:0] K_LBRACKET  = 6'd4;
  localparam logic [KindW-1:0] K_RBRACKET  = 6'd5;
  localparam logic [KindW-1:0] K_SEMI      = 6'd6;
  localparam logic [KindW-1:0] K_COMMA     = 6'd7;
  localparam logic [KindW-1:0] K_DOT       = 6'd8;
  localparam logic [KindW-1:0] K_RANGE     = 6'd9;
  localparam logic [KindW-1:0] K_MINUS     = 6'd10;
  localparam logic [KindW-1:0] K_PLUS      = 6'd12;
  localparam logic [KindW-1:0] K_SLASH     = 6'd14;
  localparam logic [KindW-1:0] K_SLASH_EQ  = 6'd15;
  localparam logic [KindW-1:0] K_STAR      = 6'd16;
  localparam logic [KindW-1:0] K_STAR_EQ   = 6'd17;
  localparam logic [KindW-1:0] K_STAR_STAR = 6'd18;
  localparam logic [KindW-1:0] K_POW_EQ    = 6'd19;
  localparam logic [KindW-1:0] K_BANG      = 6'd20;
  localparam logic [KindW-1:0] K_EQUAL     = 6'd22;
  localparam logic [KindW-1:0] K_LESS      = 6'd24;
  localparam logic [KindW-1:0] K_GREATER   = 6'd26;
  localparam logic [KindW-1:0] K_PERCENT   = 6'd28;
  localparam logic [KindW-1:0] K_COLON     = 6'd30;
  localparam logic [KindW-1:0] K_AND       = 6'd31;
  localparam logic [KindW-1:0] K_OR        = 6'd32;
  localparam logic [KindW-1:0] K_IDENT     = 6'd47;
  localparam logic [KindW-1:0] K_NUMBER    = 6'd48;
  localparam logic [KindW-1:0] K_HEX       = 6'd49;
  localparam logic [KindW-1:0] K_BIN       = 6'd50;
  localparam logic [KindW-1:0] K_STRING    = 6'd51;
  localparam logic [KindW-1:0] K_EOF       = 6'd52;
  localparam logic [KindW-1:0] K_ERROR     = 6'd53;

  localparam logic [ErrW-1:0] E_NONE       = 3'd0;
  localparam logic [ErrW-1:0] E_OPEN_CMT   = 3'd1;
  localparam logic [ErrW-1:0] E_LONE_BAR   = 3'd2;
  localparam logic [ErrW-1:0] E_LONE_AMP   = 3'd3;
  localparam logic [ErrW-1:0] E_UNEXPECTED = 3'd4;
  localparam logic [ErrW-1:0] E_HEX_LONG   = 3'd5;
  localparam logic [ErrW-1:0] E_BIN_LONG   = 3'd6;
  localparam logic [ErrW-1:0] E_OPEN_STR   = 3'd7;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_ZERO, M_INT, M_NDOT, M_FRAC, M_HEX, M_BIN, M_STRING,
    M_SLASH, M_LINE, M_BLOCK, M_STAR, M_STAR2, M_OPEQ, M_DOT, M_BAR, M_AMP
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ErrW-1:0]   err;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] len;
    logic [FieldW-1:0] line;
  } res_t;

  typedef struct packed {
    logic       found;
    logic [3:0] k;
    logic [2:0] m;
  } kw_dec_t;

  localparam logic [47:0] KW_STR [KwCount] = '{
    "and", "class", "do", "else", "false", "for", "fun", "if",
    "null", "or", "return", "super", "this", "true", "var", "while"
  };
  localparam int unsigned KW_LEN  [KwCount] = '{3, 5, 2, 4, 5, 3, 3, 2, 4, 2, 6, 5, 4, 4, 3, 5};
  localparam int unsigned KW_BASE [KwCount] =
    '{0, 3, 8, 10, 14, 19, 22, 25, 27, 31, 33, 39, 44, 48, 52, 55};
  localparam logic [KindW-1:0] KW_KIND [KwCount] =
    '{6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
      6'd40, 6'd32, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46};

  function automatic logic [7:0] kw_ch(int unsigned k, int unsigned i);
    if (i >= KW_LEN[k]) return 8'd0;
    return 8'(KW_STR[k] >> (8 * (KW_LEN[k] - 1 - i)));
  endfunction

  function automatic kw_dec_t kw_decode(logic [5:0] node);
    kw_dec_t d;
    d = '0;
    for (int unsigned k = 0; k < KwCount; k++) begin
      if (!d.found && (int'(node) > KW_BASE[k]) && (int'(node) <= KW_BASE[k] + KW_LEN[k])) begin
        d.found = 1'b1;
        d.k     = 4'(k);
        d.m     = 3'(int'(node) - KW_BASE[k]);
      end
    end
    return d;
  endfunction

  function automatic logic [5:0] kw_start(logic [7:0] c);
    logic [5:0] n;
    n = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (kw_ch(k, 0) == c) n = 6'(KW_BASE[k] + 1);
    end
    return n;
  endfunction

  function automatic logic [5:0] kw_next(logic [5:0] node, logic [7:0] c);
    kw_dec_t d;
    logic [5:0] n;
    logic ok;
    d = kw_decode(node);
    n = '0;
    if (d.found) begin
      for (int j = KwCount - 1; j >= 0; j--) begin
        ok = (KW_LEN[j] > int'(d.m)) && (kw_ch(j, d.m) == c);
        for (int unsigned i = 0; i < 6; i++) begin
          if (i < d.m && kw_ch(j, i) != kw_ch(d.k, i)) ok = 1'b0;
        end
        if (ok) n = 6'(KW_BASE[j] + d.m + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [KindW-1:0] opeq_base(logic [7:0] c);
    case (c)
      "-":     return K_MINUS;
      "+":     return K_PLUS;
      "!":     return K_BANG;
      "=":     return K_EQUAL;
      "<":     return K_LESS;
      ">":     return K_GREATER;
      default: return K_PERCENT;
    endcase
  endfunction

endpackage

### rtl/source_token_scanner_top.sv
// Top level of the source token scanner: byte stream in, token stream out.
//
// Usage:
//   Slave channel s_axis_*: one source byte per item in tdata; tlast marks the
//   end of text (its byte is ignored). A byte of value 0 also ends the text.
//   Master channel m_axis_*: one item per token. tuser carries token kind and
//   error number, tdata carries start offset, length and line. tlast is set on
//   the final token caused by one input byte.
// Tokens of an accepted byte are registered and appear in the cycle after acceptance.
// Throughput: one byte per cycle while each byte gives at most one token and
//   tready stays high; a byte that gives more tokens holds the input while the
//   single output port drains a four-entry result buffer one item a cycle.
// The byte's whole scan step is one pass of combinational logic from the
//   accepted byte and the scanner state into the result buffer.
// Reset: all counters return to offset 0, line 1, scanner idle, buffer empty.
//   The end of text returns the scanner to the same state.
// Stall: when the receiver holds tready low the current token stays on the
//   port, and the input is held until the buffer is nearly drained.
module source_token_scanner_top #(
  parameter int unsigned OFFSET_WIDTH   = sts_pkg::OffsetWidthDef,
  parameter int unsigned DEPTH_WIDTH    = sts_pkg::DepthWidthDef,
  parameter int unsigned HEX_MAX_DIGITS = sts_pkg::HexMaxDigitsDef,
  parameter int unsigned BIN_MAX_DIGITS = sts_pkg::BinMaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [23:0] start_offset, [47:24] token_length,
                                        // [71:48] line_number
  output logic [8:0]  m_axis_tuser_o,   // [5:0] token_kind, [8:6] error_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned OW     = OFFSET_WIDTH;
  localparam int unsigned MaxDig = (HEX_MAX_DIGITS > BIN_MAX_DIGITS) ? HEX_MAX_DIGITS
                                                                      : BIN_MAX_DIGITS;
  localparam int unsigned DGW    = $clog2(MaxDig + 2);
  localparam logic [OW-1:0]          PosMax   = '1;
  localparam logic [DEPTH_WIDTH-1:0] DepthMax = '1;
  localparam int unsigned IdxW = $clog2(sts_pkg::ResDepth);
  localparam int unsigned CntW = $clog2(sts_pkg::ResDepth + 1);

  typedef struct packed {
    logic          emit;
    sts_pkg::res_t r;
    sts_pkg::mode_e mode;
    logic [OW-1:0] tb;
  } fin_t;

  // Scanner state
  logic [OW-1:0]          line_q, line_d, pos_q, pos_d, tb_q, tb_d;
  sts_pkg::mode_e         mode_q, mode_d;
  logic [DEPTH_WIDTH-1:0] depth_q, depth_d;
  logic [5:0]             kw_q, kw_d;
  logic [DGW-1:0]         dig_q, dig_d;
  logic [7:0]             held_q, held_d;
  logic                   esc_q, esc_d;

  // Result buffer
  sts_pkg::res_t          res_q [sts_pkg::ResDepth];
  sts_pkg::res_t          res_d [sts_pkg::ResDepth];
  logic [CntW-1:0]        cnt_q, cnt_d, idx_q;

  logic in_acc, out_acc;

  function automatic logic [OW-1:0] sat_inc(logic [OW-1:0] v);
    return (v == PosMax) ? v : v + OW'(1);
  endfunction

  function automatic logic [OW-1:0] span(logic [OW-1:0] a, logic [OW-1:0] b);
    return (b > a) ? b - a : '0;
  endfunction

  function automatic sts_pkg::res_t mk(logic [sts_pkg::KindW-1:0] kind,
                                       logic [sts_pkg::ErrW-1:0] err,
                                       logic [OW-1:0] start, logic [OW-1:0] len);
    sts_pkg::res_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = sts_pkg::FieldW'(start);
    r.len   = sts_pkg::FieldW'(len);
    r.line  = sts_pkg::FieldW'(line_q);
    return r;
  endfunction

  // Close the pending token before offset p.
  function automatic fin_t finish(sts_pkg::mode_e mode, logic [OW-1:0] tb, logic [5:0] kw,
                                  logic [DGW-1:0] dig, logic [7:0] held, logic [OW-1:0] p);
    fin_t f;
    sts_pkg::kw_dec_t d;
    logic [OW-1:0] len, dot;
    len    = span(tb, p);
    d      = sts_pkg::kw_decode(kw);
    dot    = (p > tb) ? p - OW'(1) : p;
    f.emit = 1'b1;
    f.mode = sts_pkg::M_IDLE;
    f.tb   = tb;
    f.r    = mk(sts_pkg::K_IDENT, sts_pkg::E_NONE, tb, len);
    case (mode)
      sts_pkg::M_IDENT: begin
        if (d.found && int'(d.m) == sts_pkg::KW_LEN[d.k]) f.r.kind = sts_pkg::KW_KIND[d.k];
      end
      sts_pkg::M_ZERO, sts_pkg::M_INT, sts_pkg::M_FRAC: f.r.kind = sts_pkg::K_NUMBER;
      sts_pkg::M_NDOT: begin
        // Emit the number and keep the dot pending as its own token
        f.r  = mk(sts_pkg::K_NUMBER, sts_pkg::E_NONE, tb, span(tb, dot));
        f.tb = dot;
        f.mode = sts_pkg::M_DOT;
      end
      sts_pkg::M_HEX: begin
        if (dig > DGW'(HEX_MAX_DIGITS)) f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_HEX_LONG, tb, len);
        else f.r.kind = sts_pkg::K_HEX;
      end
      sts_pkg::M_BIN: begin
        if (dig > DGW'(BIN_MAX_DIGITS)) f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_BIN_LONG, tb, len);
        else f.r.kind = sts_pkg::K_BIN;
      end
      sts_pkg::M_STRING: f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_OPEN_STR, tb, len);
      sts_pkg::M_BLOCK:  f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_OPEN_CMT, tb, len);
      sts_pkg::M_SLASH:  f.r.kind = sts_pkg::K_SLASH;
      sts_pkg::M_STAR:   f.r.kind = sts_pkg::K_STAR;
      sts_pkg::M_STAR2:  f.r.kind = sts_pkg::K_STAR_STAR;
      sts_pkg::M_OPEQ:   f.r.kind = sts_pkg::opeq_base(held);
      sts_pkg::M_DOT:    f.r.kind = sts_pkg::K_DOT;
      sts_pkg::M_BAR:    f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_LONE_BAR, tb, len);
      sts_pkg::M_AMP:    f.r = mk(sts_pkg::K_ERROR, sts_pkg::E_LONE_AMP, tb, len);
      default:           f.emit = 1'b0;
    endcase
    return f;
  endfunction

  // One scan step for the incoming byte
  always_comb begin
    logic [7:0]    c;
    logic [OW-1:0] p, len1;
    logic          again, act;
    logic [CntW-1:0] n;
    fin_t          f;
    c    = s_axis_tdata_i;
    p    = pos_q;
    n    = '0;
    f    = '0;
    len1 = '0;
    again = 1'b0;
    act   = 1'b1;
    for (int unsigned i = 0; i < sts_pkg::ResDepth; i++) res_d[i] = '0;
    mode_d  = mode_q;
    tb_d    = tb_q;
    kw_d    = kw_q;
    dig_d   = dig_q;
    held_d  = held_q;
    esc_d   = esc_q;
    depth_d = depth_q;
    if (s_axis_tlast_i || c == 8'd0) begin
      // Flush what is pending, emit the end token, start a fresh text
      for (int unsigned i = 0; i < 2; i++) begin
        if (mode_d != sts_pkg::M_IDLE) begin
          f = finish(mode_d, tb_d, kw_d, dig_d, held_d, p);
          if (f.emit) begin
            res_d[n[IdxW-1:0]] = f.r;
            n = n + CntW'(1);
          end
          mode_d = f.mode;
          tb_d   = f.tb;
        end
      end
      res_d[n[IdxW-1:0]] = mk(sts_pkg::K_EOF, sts_pkg::E_NONE, p, '0);
      n       = n + CntW'(1);
      line_d  = OW'(1);
      pos_d   = '0;
      tb_d    = '0;
      mode_d  = sts_pkg::M_IDLE;
      depth_d = '0;
      kw_d    = '0;
      dig_d   = '0;
      held_d  = '0;
      esc_d   = 1'b0;
    end else begin
      for (int unsigned i = 0; i < 3; i++) begin
        if (act) begin
          again = 1'b0;
          len1  = span(tb_d, sat_inc(p));
          case (mode_d)
            sts_pkg::M_IDLE: begin
              tb_d = p;
              if (c inside {" ", 8'h0d, 8'h09, 8'h0a}) begin
              end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
                mode_d = sts_pkg::M_IDENT;
                kw_d   = sts_pkg::kw_start(c);
              end else if (c inside {["0":"9"]}) begin
                mode_d = (c == "0") ? sts_pkg::M_ZERO : sts_pkg::M_INT;
              end else begin
                case (c)
                  "(", ")", "{", "}", "[", "]", ";", ",", ":": begin
                    case (c)
                      "(":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_LPAREN, '0, p, OW'(1));
                      ")":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_RPAREN, '0, p, OW'(1));
                      "{":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_LBRACE, '0, p, OW'(1));
                      "}":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_RBRACE, '0, p, OW'(1));
                      "[":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_LBRACKET, '0, p, OW'(1));
                      "]":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_RBRACKET, '0, p, OW'(1));
                      ";":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_SEMI, '0, p, OW'(1));
                      ",":     res_d[n[IdxW-1:0]] = mk(sts_pkg::K_COMMA, '0, p, OW'(1));
                      default: res_d[n[IdxW-1:0]] = mk(sts_pkg::K_COLON, '0, p, OW'(1));
                    endcase
                    n = n + CntW'(1);
                  end
                  ".": mode_d = sts_pkg::M_DOT;
                  "/": mode_d = sts_pkg::M_SLASH;
                  "*": mode_d = sts_pkg::M_STAR;
                  "\"": begin
                    mode_d = sts_pkg::M_STRING;
                    esc_d  = 1'b0;
                  end
                  "|": mode_d = sts_pkg::M_BAR;
                  "&": mode_d = sts_pkg::M_AMP;
                  "-", "+", "!", "=", "<", ">", "%": begin
                    mode_d = sts_pkg::M_OPEQ;
                    held_d = c;
                  end
                  default: begin
                    res_d[n[IdxW-1:0]] = mk(sts_pkg::K_ERROR, sts_pkg::E_UNEXPECTED, p, OW'(1));
                    n = n + CntW'(1);
                  end
                endcase
              end
            end
            sts_pkg::M_IDENT: begin
              if (c inside {["a":"z"], ["A":"Z"], "_", ["0":"9"]}) kw_d = sts_pkg::kw_next(kw_d, c);
              else again = 1'b1;
            end
            sts_pkg::M_ZERO: begin
              if (c inside {["0":"9"]}) mode_d = sts_pkg::M_INT;
              else if (c == "x" || c == "X") begin
                mode_d = sts_pkg::M_HEX;
                dig_d  = '0;
              end else if (c == "b" || c == "B") begin
                mode_d = sts_pkg::M_BIN;
                dig_d  = '0;
              end else if (c == ".") mode_d = sts_pkg::M_NDOT;
              else again = 1'b1;
            end
            sts_pkg::M_INT: begin
              if (c == ".") mode_d = sts_pkg::M_NDOT;
              else if (!(c inside {["0":"9"]})) again = 1'b1;
            end
            sts_pkg::M_NDOT: begin
              if (c inside {["0":"9"]}) mode_d = sts_pkg::M_FRAC;
              else again = 1'b1;
            end
            sts_pkg::M_FRAC: begin
              if (!(c inside {["0":"9"]})) again = 1'b1;
            end
            sts_pkg::M_HEX: begin
              if (c inside {["0":"9"], ["a":"f"], ["A":"F"]}) begin
                if (dig_d <= DGW'(HEX_MAX_DIGITS)) dig_d = dig_d + DGW'(1);
              end else again = 1'b1;
            end
            sts_pkg::M_BIN: begin
              if (c == "0" || c == "1") begin
                if (dig_d <= DGW'(BIN_MAX_DIGITS)) dig_d = dig_d + DGW'(1);
              end else again = 1'b1;
            end
            sts_pkg::M_STRING: begin
              if (esc_d) esc_d = 1'b0;
              else if (c == "\\") esc_d = 1'b1;
              else if (c == "\"") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_STRING, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end
            end
            sts_pkg::M_SLASH: begin
              if (c == "/") mode_d = sts_pkg::M_LINE;
              else if (c == "*") begin
                mode_d  = sts_pkg::M_BLOCK;
                depth_d = DEPTH_WIDTH'(1);
                held_d  = '0;
              end else if (c == "=") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_SLASH_EQ, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_LINE: begin
              if (c == 8'h0a) mode_d = sts_pkg::M_IDLE;
            end
            sts_pkg::M_BLOCK: begin
              // Close or open one nesting level; a byte joins at most one pair
              if (held_d == "*" && c == "/") begin
                held_d = '0;
                if (depth_d != '0) depth_d = depth_d - DEPTH_WIDTH'(1);
                if (depth_d == '0) mode_d = sts_pkg::M_IDLE;
              end else if (held_d == "/" && c == "*") begin
                held_d = '0;
                if (depth_d != DepthMax) depth_d = depth_d + DEPTH_WIDTH'(1);
              end else begin
                held_d = (c == "*" || c == "/") ? c : 8'd0;
              end
            end
            sts_pkg::M_STAR: begin
              if (c == "*") mode_d = sts_pkg::M_STAR2;
              else if (c == "=") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_STAR_EQ, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_STAR2: begin
              if (c == "=") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_POW_EQ, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_OPEQ: begin
              if (c == "=") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::opeq_base(held_d) + 6'd1, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_DOT: begin
              if (c == ".") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_RANGE, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_BAR: begin
              if (c == "|") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_OR, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            sts_pkg::M_AMP: begin
              if (c == "&") begin
                res_d[n[IdxW-1:0]] = mk(sts_pkg::K_AND, '0, tb_d, len1);
                n = n + CntW'(1);
                mode_d = sts_pkg::M_IDLE;
              end else again = 1'b1;
            end
            default: begin
              mode_d = sts_pkg::M_IDLE;
              again  = 1'b1;
            end
          endcase
          if (again) begin
            // Byte does not extend the token: close it and rescan the byte
            f = finish(mode_d, tb_d, kw_d, dig_d, held_d, p);
            if (f.emit) begin
              res_d[n[IdxW-1:0]] = f.r;
              n = n + CntW'(1);
            end
            mode_d = f.mode;
            tb_d   = f.tb;
          end
          act = again;
        end
      end
      line_d = (c == 8'h0a) ? sat_inc(line_q) : line_q;
      pos_d  = sat_inc(p);
    end
    cnt_d = n;
  end

  // Take a new byte when no buffered token is left, or one is left and it leaves now
  assign s_axis_tready_o = (idx_q == cnt_q) ||
                           ((idx_q + CntW'(1) == cnt_q) && m_axis_tready_i);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= OW'(1);
      pos_q   <= '0;
      tb_q    <= '0;
      mode_q  <= sts_pkg::M_IDLE;
      depth_q <= '0;
      kw_q    <= '0;
      dig_q   <= '0;
      held_q  <= '0;
      esc_q   <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (in_acc) begin
      line_q  <= line_d;
      pos_q   <= pos_d;
      tb_q    <= tb_d;
      mode_q  <= mode_d;
      depth_q <= depth_d;
      kw_q    <= kw_d;
      dig_q   <= dig_d;
      held_q  <= held_d;
      esc_q   <= esc_d;
      cnt_q   <= cnt_d;
      idx_q   <= '0;
    end else if (out_acc) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int unsigned i = 0; i < sts_pkg::ResDepth; i++) res_q[i] <= res_d[i];
    end
  end

  assign m_axis_tvalid_o = (idx_q != cnt_q);
  assign m_axis_tlast_o  = (idx_q + CntW'(1) == cnt_q);
  assign m_axis_tdata_o  = {res_q[idx_q[IdxW-1:0]].line, res_q[idx_q[IdxW-1:0]].len,
                            res_q[idx_q[IdxW-1:0]].start};
  assign m_axis_tuser_o  = {res_q[idx_q[IdxW-1:0]].err, res_q[idx_q[IdxW-1:0]].kind};

endmodule

### rtl/sts_checker.sv
// Port-level assertions of the source token scanner and their binding.
module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [8:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[5:0] == sts_pkg::K_EOF |-> m_axis_tlast_o)
    else $error("end token is not last of its run");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[8:6] != sts_pkg::E_NONE
      |-> m_axis_tuser_o[5:0] == sts_pkg::K_ERROR)
    else $error("error number on a non-error token");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[5:0] == sts_pkg::K_ERROR
      |-> m_axis_tuser_o[8:6] != sts_pkg::E_NONE)
    else $error("error token without error number");

endmodule

bind source_token_scanner_top sts_checker u_sts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
